/* src/gost_94_hash_engine_unit_assert.svh */
// Assertion macros shared by the hash engine RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef GOST_94_HASH_ENGINE_UNIT_ASSERT_SVH
`define GOST_94_HASH_ENGINE_UNIT_ASSERT_SVH
// same-cycle implication
`define GOST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GOST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* src/gost_pkg.sv */
// Package for the GOST R 34.11-94 hash engine: command type, S-boxes,
// key schedule helpers, cipher round and psi shift. No dependencies.
`default_nettype none
package gost_pkg;

  localparam int unsigned BYTES_PER_ITEM = 8;

  typedef struct packed {
    logic [255:0] blk;
    logic         do_block;
    logic         do_final;
    logic [63:0]  len;
  } gost_cmd_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
      4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
    '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
      4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
    '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
      4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
    '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
      4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
    '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
      4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
    '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
      4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
      4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
    '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
      4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
  };

  // byte 0 in bits 7..0
  localparam logic [255:0] KEY_C3 =
    256'hff00ffff000000ff_ff0000ff00ffff00_00ff00ff00ff00ff_ff00ff00ff00ff00;

  function automatic logic [255:0] shift_a(input logic [255:0] y);
    return {y[63:0] ^ y[127:64], y[255:64]};
  endfunction

  function automatic logic [255:0] perm_p(input logic [255:0] y);
    logic [255:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 8; k++) begin
        r[8*(i+4*k) +: 8] = y[8*(8*i+k) +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] round_f(input logic [31:0] a, input logic [31:0] k);
    logic [31:0] s;
    logic [31:0] r;
    s = a + k;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SBOX[i][s[4*i +: 4]];
    end
    return {r[20:0], r[31:21]};
  endfunction

  function automatic logic [255:0] psi_step(input logic [255:0] y);
    logic [15:0] t;
    t = y[15:0] ^ y[31:16] ^ y[47:32] ^ y[63:48] ^ y[207:192] ^ y[255:240];
    return {t, y[255:16]};
  endfunction

endpackage
`default_nettype wire

/* src/gost_fe.sv */
// Front end: packs message bytes into 32-byte blocks, counts the bit length
// and issues block/final commands. Uses gost_pkg.
`default_nettype none
module gost_fe
  import gost_pkg::*;
#(
  parameter int unsigned ITEM_BYTES = BYTES_PER_ITEM
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             push_valid,
  input  wire logic        push_ready,
  output gost_cmd_t        push_cmd
);

  localparam logic [3:0] BPI = 4'(ITEM_BYTES);

  logic [255:0] store_r, store_nxt;
  logic [4:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic         flush_r, flush_nxt;

  logic [3:0]   cnt;
  logic [63:0]  mword;
  logic [319:0] gbuf;
  logic [5:0]   total;
  logic [5:0]   rem;
  logic [64:0]  lsum;
  logic [63:0]  lnew;
  logic         accept;

  assign in_ready = !flush_r && push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt = (in_byte_count > BPI) ? BPI : in_byte_count;
    for (int b = 0; b < 8; b++) begin
      mword[8*b +: 8] = (4'(b) < cnt) ? in_message_word[8*b +: 8] : 8'h00;
    end
    gbuf  = {64'h0, store_r} | ({256'h0, mword} << {fill_r, 3'b000});
    total = {1'b0, fill_r} + {2'b00, cnt};
    rem   = total - 6'd32;
    lsum  = {1'b0, len_r} + {58'h0, cnt, 3'b000};
    lnew  = lsum[64] ? {64{1'b1}} : lsum[63:0];
  end

  always_comb begin
    store_nxt  = store_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    flush_nxt  = flush_r;
    push_valid = 1'b0;
    push_cmd   = '{blk: gbuf[255:0], do_block: 1'b1, do_final: 1'b0, len: lnew};
    if (flush_r) begin
      push_cmd = '{blk: store_r, do_block: 1'b1, do_final: 1'b1, len: len_r};
      if (push_ready) begin
        push_valid = 1'b1;
        store_nxt  = '0;
        fill_nxt   = '0;
        len_nxt    = '0;
        flush_nxt  = 1'b0;
      end
    end else if (accept) begin
      len_nxt = lnew;
      if (total[5]) begin
        push_valid = 1'b1;
        store_nxt  = {192'h0, gbuf[319:256]};
        fill_nxt   = rem[4:0];
        if (in_last_word) begin
          if (rem != 6'd0) begin
            // remainder goes out as a second command from the flush state once the queue has room
            flush_nxt = 1'b1;
          end else begin
            push_cmd.do_final = 1'b1;
            store_nxt = '0;
            len_nxt   = '0;
          end
        end
      end else if (in_last_word) begin
        push_valid        = 1'b1;
        push_cmd.do_block = (total != 6'd0);
        push_cmd.do_final = 1'b1;
        store_nxt = '0;
        fill_nxt  = '0;
        len_nxt   = '0;
      end else begin
        store_nxt = gbuf[255:0];
        fill_nxt  = total[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      flush_r <= 1'b0;
    end else begin
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/gost_q.sv */
// Two-entry command queue between front end and compression back end.
// Uses gost_pkg for the command type.
`default_nettype none
module gost_q
  import gost_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  gost_cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output gost_cmd_t pop_cmd
);

  gost_cmd_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* src/gost_be.sv */
// Back end: step function (key schedule, four cipher lanes, psi shuffle),
// checksum, final length/sum passes and digest output. Uses gost_pkg.
`default_nettype none
module gost_be
  import gost_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  gost_cmd_t        pop_cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_result
);

`include "gost_94_hash_engine_unit_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_KEY  = 5'b00010,
    ST_ENC  = 5'b00100,
    ST_PSI  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_BLK = 2'd0,
    OP_LEN = 2'd1,
    OP_SUM = 2'd2
  } op_t;

  state_t       state_r;
  op_t          op_r;
  logic         fin_r;
  logic [63:0]  len_r;
  logic [255:0] chain_r, check_r, m_r, s_r;
  logic [255:0] key_r [4];
  logic [4:0]   round_r;
  logic [6:0]   psi_r;
  logic         carry_r;
  logic [1:0]   oidx_r;

  logic [255:0] u1, u2, u3, v1, v2, v3;
  logic [255:0] s_enc, psi_in, psi_out;
  logic [2:0]   kidx;
  logic [64:0]  csum;
  logic         out_hs;

  assign pop_ready       = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = chain_r[64*oidx_r +: 64];
  assign out_word_index  = oidx_r;
  assign out_last_result = (oidx_r == 2'd3);
  assign out_hs          = out_valid && out_ready;

  always_comb begin
    u1 = shift_a(chain_r);
    u2 = shift_a(u1) ^ KEY_C3;
    u3 = shift_a(u2);
    v1 = shift_a(shift_a(m_r));
    v2 = shift_a(shift_a(v1));
    v3 = shift_a(shift_a(v2));
    kidx = (round_r < 5'd24) ? round_r[2:0] : ~round_r[2:0];
    for (int g = 0; g < 4; g++) begin
      logic [31:0] lo, hi, t;
      lo = s_r[64*g +: 32];
      hi = s_r[64*g+32 +: 32];
      t  = round_f(lo, key_r[g][32*kidx +: 32]) ^ hi;
      // last round does not swap the halves
      s_enc[64*g +: 64] = (round_r == 5'd31) ? {t, lo} : {lo, t};
    end
    psi_in = s_r ^ ((psi_r == 7'd12) ? m_r : 256'h0)
                 ^ ((psi_r == 7'd13) ? chain_r : 256'h0);
    psi_out = psi_step(psi_in);
    csum = {1'b0, check_r[64*round_r[1:0] +: 64]} + {1'b0, m_r[64*round_r[1:0] +: 64]}
         + {64'h0, carry_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_BLK;
      fin_r   <= 1'b0;
      chain_r <= '0;
      check_r <= '0;
      round_r <= '0;
      psi_r   <= '0;
      carry_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            len_r <= pop_cmd.len;
            fin_r <= pop_cmd.do_final;
            if (pop_cmd.do_block) begin
              op_r <= OP_BLK;
              m_r  <= pop_cmd.blk;
            end else begin
              op_r <= OP_LEN;
              m_r  <= {192'h0, pop_cmd.len};
            end
            state_r <= ST_KEY;
          end
        end
        ST_KEY: begin
          key_r[0] <= perm_p(chain_r ^ m_r);
          key_r[1] <= perm_p(u1 ^ v1);
          key_r[2] <= perm_p(u2 ^ v2);
          key_r[3] <= perm_p(u3 ^ v3);
          s_r      <= chain_r;
          round_r  <= '0;
          carry_r  <= 1'b0;
          state_r  <= ST_ENC;
        end
        ST_ENC: begin
          s_r <= s_enc;
          // checksum, one 64-bit word a cycle over the first rounds
          if (op_r == OP_BLK && round_r < 5'd4) begin
            check_r[64*round_r[1:0] +: 64] <= csum[63:0];
            carry_r <= csum[64];
          end
          round_r <= round_r + 5'd1;
          if (round_r == 5'd31) begin
            psi_r   <= '0;
            state_r <= ST_PSI;
          end
        end
        ST_PSI: begin
          s_r   <= psi_out;
          psi_r <= psi_r + 7'd1;
          if (psi_r == 7'd73) begin
            chain_r <= psi_out;
            case (op_r)
              OP_BLK: begin
                if (fin_r) begin
                  op_r    <= OP_LEN;
                  m_r     <= {192'h0, len_r};
                  state_r <= ST_KEY;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              OP_LEN: begin
                op_r    <= OP_SUM;
                m_r     <= check_r;
                state_r <= ST_KEY;
              end
              default: begin
                oidx_r  <= '0;
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_hs) begin
            oidx_r <= oidx_r + 2'd1;
            if (oidx_r == 2'd3) begin
              chain_r <= '0;
              check_r <= '0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `GOST_ASSERT_NEXT(a_pop_starts, pop_valid && pop_ready, state_r == ST_KEY, "pop did not start a pass")
  `GOST_ASSERT_NEXT(a_enc_to_psi, state_r == ST_ENC && round_r == 5'd31, state_r == ST_PSI && psi_r == 7'd0, "cipher end did not start psi")
  `GOST_ASSERT_NEXT(a_msg_clear, out_hs && out_last_result, state_r == ST_IDLE && chain_r == '0 && check_r == '0, "state not cleared after digest")

endmodule
`default_nettype wire

/* src/gost_94_hash_engine_unit.sv */
// GOST R 34.11-94 hash engine. A full 32-byte block passes through the back
// end as pop, key load, 32 rounds on four cipher lanes and 74 psi shifts at
// one a cycle; the back end takes no new block until that pass is done.
// For the final item, the last block, length and checksum passes run before the
// first digest word, then one word per cycle as the sink allows.
// Synchronous active-low reset clears chain value, checksum, length and queue.
`default_nettype none
module gost_94_hash_engine_unit
  import gost_pkg::*;
#(
  parameter int unsigned ITEM_BYTES = BYTES_PER_ITEM
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_result
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  gost_cmd_t push_cmd, pop_cmd;

  gost_fe #(.ITEM_BYTES(ITEM_BYTES)) u_fe (
    .clk, .rst_n, .in_valid, .in_ready, .in_message_word, .in_byte_count,
    .in_last_word, .push_valid, .push_ready, .push_cmd
  );

  gost_q u_q (
    .clk, .rst_n, .push_valid, .push_ready, .push_cmd,
    .pop_valid, .pop_ready, .pop_cmd
  );

  gost_be u_be (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_cmd, .out_valid, .out_ready,
    .out_digest_word, .out_word_index, .out_last_result
  );

endmodule
`default_nettype wire

/* dv/tb_gost_94_hash_engine_unit.sv */
// Self-checking testbench for the GOST R 34.11-94 hash engine unit.
// Predicts digests with its own step function; needs gost_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_gost_94_hash_engine_unit;
  import gost_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } msg_item_t;

  typedef struct {
    logic [63:0] digest;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_message_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_result;

  msg_item_t    pending_items[$];
  digest_word_t digest_q[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           in_xfer = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           flow_left = 0;

  // running hash state
  logic [255:0] chain_h = '0;
  logic [255:0] sum_h = '0;
  logic [255:0] block_h = '0;
  int           fill_h = 0;
  logic [63:0]  len_h = '0;

  gost_94_hash_engine_unit uut (.*);

  always #5 clk = ~clk;

  function automatic logic [255:0] lfsr_a(input logic [255:0] y);
    return {y[63:0] ^ y[127:64], y[255:64]};
  endfunction

  function automatic logic [255:0] key_perm(input logic [255:0] y);
    logic [255:0] r;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 8; k++)
        r[8*(i+4*k) +: 8] = y[8*(8*i+k) +: 8];
    return r;
  endfunction

  function automatic logic [255:0] psi_shift(input logic [255:0] y, input int n);
    logic [15:0] t;
    for (int r = 0; r < n; r++) begin
      t = y[15:0] ^ y[31:16] ^ y[47:32] ^ y[63:48] ^ y[207:192] ^ y[255:240];
      y = {t, y[255:16]};
    end
    return y;
  endfunction

  function automatic logic [63:0] cipher64(input logic [63:0] d, input logic [255:0] key);
    logic [31:0] a, b, t, s, r;
    int idx;
    a = d[31:0];
    b = d[63:32];
    for (int rnd = 0; rnd < 32; rnd++) begin
      idx = (rnd < 24) ? (rnd % 8) : (31 - rnd);
      s = a + key[32*idx +: 32];
      for (int i = 0; i < 8; i++) r[4*i +: 4] = SBOX[i][s[4*i +: 4]];
      t = {r[20:0], r[31:21]} ^ b;
      b = a;
      a = t;
    end
    return {a, b};
  endfunction

  function automatic logic [255:0] step_fn(input logic [255:0] h, input logic [255:0] m);
    logic [255:0] u, v, s;
    logic [255:0] keys[4];
    u = h;
    v = m;
    keys[0] = key_perm(u ^ v);
    for (int j = 1; j < 4; j++) begin
      u = lfsr_a(u);
      if (j == 2) u = u ^ KEY_C3;
      v = lfsr_a(lfsr_a(v));
      keys[j] = key_perm(u ^ v);
    end
    s = h;
    for (int i = 0; i < 4; i++) s[64*i +: 64] = cipher64(s[64*i +: 64], keys[i]);
    s = psi_shift(s, 12) ^ m;
    s = psi_shift(s, 1) ^ h;
    return psi_shift(s, 61);
  endfunction

  task automatic absorb_block();
    chain_h = step_fn(chain_h, block_h);
    sum_h = sum_h + block_h;
    block_h = '0;
    fill_h = 0;
  endtask

  task automatic hash_item(input msg_item_t it);
    int n;
    n = (it.count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : it.count;
    for (int i = 0; i < n; i++) begin
      block_h[8*fill_h +: 8] = it.word[8*i +: 8];
      fill_h++;
      len_h = (len_h > 64'hffff_ffff_ffff_fff7) ? '1 : len_h + 64'd8;
      if (fill_h == 32) absorb_block();
    end
    if (it.last) begin
      if (fill_h != 0) absorb_block();
      chain_h = step_fn(chain_h, {192'd0, len_h});
      chain_h = step_fn(chain_h, sum_h);
      for (int i = 0; i < 4; i++)
        digest_q.insert(digest_q.size(),
                        digest_word_t'{chain_h[64*i +: 64], 2'(i), i == 3});
      chain_h = '0;
      sum_h = '0;
      block_h = '0;
      fill_h = 0;
      len_h = '0;
    end
  endtask

  task automatic add_item(input logic [63:0] w, input int c, input bit l);
    pending_items.insert(pending_items.size(), msg_item_t'{w, 4'(c), l});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    digest_word_t exp_w;
    in_xfer = in_valid && in_ready;
    if (rst_n) begin
      if (in_xfer) hash_item('{in_message_word, in_byte_count, in_last_word});
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          fail_count++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_word !== exp_w.digest) begin
            $error("digest_word exp %h got %h", exp_w.digest, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== exp_w.index) begin
            $error("word_index exp %0d got %0d", exp_w.index, out_word_index);
            fail_count++;
          end
          if (out_last_result !== exp_w.last) begin
            $error("last_result exp %0d got %0d", exp_w.last, out_last_result);
            fail_count++;
          end
        end
      end
      if (in_xfer || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_gost_94_hash_engine_unit failed");
        $finish;
      end
    end
  end

  // driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    msg_item_t it;
    if (rst_n && (!in_valid || in_xfer)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_message_word <= it.word;
        in_byte_count <= it.count;
        in_last_word <= it.last;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // sink: alternate free-flowing stretches with random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (flow_left > 0) begin
        out_ready <= 1'b1;
        flow_left--;
      end else begin
        out_ready <= 1'b1;
        flow_left = $urandom_range(0, 30);
        stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end
    end
  end

  initial begin
    int n_items;
    int total;
    // empty message
    add_item(rand64(), 0, 1'b1);
    // extremes of the word, oversize counts clamp to eight bytes
    add_item('1, 8, 1'b0);
    add_item('0, 8, 1'b0);
    add_item('1, 15, 1'b0);
    add_item(64'h0123_4567_89ab_cdef, 9, 1'b1);
    // exactly one block, then a block plus a partial tail
    for (int i = 0; i < 4; i++) add_item(rand64(), 8, i == 3);
    for (int i = 0; i < 5; i++) add_item(rand64(), 8, 1'b0);
    add_item('1, 3, 1'b1);
    // odd byte counts, ignored high bytes, zero-byte items mid message
    add_item('1, 1, 1'b0);
    add_item('1, 0, 1'b0);
    add_item(rand64(), 7, 1'b0);
    add_item(rand64(), 5, 1'b1);
    add_item('0, 0, 1'b0);
    add_item('0, 0, 1'b1);
    total = pending_items.size();
    while (total < 120) begin
      n_items = $urandom_range(1, 14);
      for (int i = 0; i < n_items; i++)
        add_item(rand64(),
                 ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(0, 15),
                 i == n_items - 1);
      total += n_items;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || digest_q.size() != 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("tb_gost_94_hash_engine_unit passed");
    end else begin
      $display("tb_gost_94_hash_engine_unit failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
